@@ rtl/core/bidirectional_substring_search_macros.svh @@
// Assertion macros for the substring search block.
// Users provide clk_i and rst_ni in the including module.
`ifndef BIDIRECTIONAL_SUBSTRING_SEARCH_MACROS_SVH
`define BIDIRECTIONAL_SUBSTRING_SEARCH_MACROS_SVH

// Same-cycle property, checked out of reset.
`define BSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bss_pkg.sv @@
// Shared types and constants of the substring search block.
// No dependencies.
package bss_pkg;

  localparam int unsigned CHAR_W    = 16;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned MPOS_W    = 17;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned NUM_PAT   = 16;
  localparam int unsigned PIDX_W    = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH  = 3'd0,
    CFG_SEARCH_BACKWARD = 3'd1,
    CFG_PATTERN_WORD_0  = 3'd2,
    CFG_PATTERN_WORD_1  = 3'd3,
    CFG_PATTERN_WORD_2  = 3'd4,
    CFG_PATTERN_WORD_3  = 3'd5
  } cfg_idx_e;

  typedef logic [NUM_PAT-1:0][CHAR_W-1:0] pat_chars_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic              found;
    logic [MPOS_W-1:0] match_position;
  } out_word_t;

  function automatic logic [CHAR_W-1:0] pat_char(pat_chars_t chars, logic [PIDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = '0;
    if (idx < PIDX_W'(NUM_PAT)) begin
      c = chars[idx[3:0]];
    end
    return c;
  endfunction

endpackage

@@ rtl/core/bss_if.sv @@
// Stream channels of the substring search block: character input and result output.
// Depends on bss_pkg for field widths.
interface bss_in_if import bss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic [POS_W-1:0]  char_position;
  logic              scan_end;

  modport source (output valid, char_code, char_position, scan_end, input ready);
  modport sink (input valid, char_code, char_position, scan_end, output ready);
endinterface

interface bss_out_if import bss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [MPOS_W-1:0] match_position;

  modport source (output valid, found, match_position, input ready);
  modport sink (input valid, found, match_position, output ready);
endinterface

@@ rtl/core/bss_cell.sv @@
// One window cell: holds one text character, passes it to the next cell on a shift,
// and compares the character it loads with its expected pattern character. Uses bss_pkg.
module bss_cell import bss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic [CHAR_W-1:0] want_i,
  input  logic              active_i,
  output logic [CHAR_W-1:0] char_o,
  output logic              hit_o
);

  logic [CHAR_W-1:0] char_q, char_d;

  always_comb begin
    char_d = char_q;
    if (ctl_i.clear) begin
      char_d = '0;
    end else if (ctl_i.shift) begin
      char_d = char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  assign char_o = char_q;
  assign hit_o  = !active_i || (char_i == want_i);

endmodule

@@ rtl/core/bss_out_buf.sv @@
// Two-entry result buffer between the match logic and the output channel.
// Uses bss_pkg and the bss_out_if channel.
module bss_out_buf import bss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_word_t word_i,
  output logic      ready_o,
  bss_out_if.source out_o
);

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_word_t main_q, main_d;
  out_word_t skid_q, skid_d;
  logic      pop;

  assign pop = main_valid_q && out_o.ready;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop || !main_valid_q) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = word_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign ready_o              = !skid_valid_q;
  assign out_o.valid          = main_valid_q;
  assign out_o.found          = main_q.found;
  assign out_o.match_position = main_q.match_position;

endmodule

@@ rtl/core/bidirectional_substring_search.sv @@
// Top level of the streaming substring search block.
// Depends on bss_pkg, bss_if, bss_cell, bss_out_buf and the assertion macros.
//
// Usage:
// Characters enter on in_i, one word per cycle while in_i.ready is high, each with
// its buffer position and a scan_end flag on the last character of a scan. Results
// leave on out_o: found with the match position, or a not-found word on the last
// character of a scan that had no match. A scan gives at most one result.
// The pattern, its length and the direction must be written through the cfg_we_i,
// cfg_idx_i and cfg_wdata_i port while no word is in flight; the block does not check.
// A row of MAX_PATTERN cells holds the window; all cells shift and compare in
// the same cycle, so the block takes one word every cycle while in_i.ready is high.
// A result is registered in the output buffer before it appears on out_o.
// Reset clears the window and scan state, sets the pattern length to one and the
// direction, pattern and buffer valid flags to zero. When the receiver stalls, the
// two-entry result buffer keeps accepting; in_i.ready drops only when both are full.
`include "bidirectional_substring_search_macros.svh"

module bidirectional_substring_search import bss_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned BUFFER_SIZE = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  bss_in_if.sink               in_i,
  bss_out_if.source            out_o
);

  localparam int unsigned FW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned LW = (FW > 5) ? FW : 5;
  localparam logic [31:0] BUF_SZ = 32'(BUFFER_SIZE);
  localparam logic [MPOS_W-1:0] BUF_CAP = BUF_SZ[MPOS_W-1:0];

  logic [4:0]                      plen_q, plen_d;
  logic                            back_q, back_d;
  logic [NUM_WORDS-1:0][CFG_W-1:0] pat_q, pat_d;
  logic [LW-1:0]                   fill_q, fill_d;
  logic                            done_q, done_d;

  pat_chars_t                           pat_chars;
  logic [LW-1:0]                        plen_ext, len_eff, fill_nxt;
  logic                                 accept, buf_ready, hit_now, res_push;
  cell_ctl_t                            cell_ctl;
  logic [MAX_PATTERN-1:0][CHAR_W-1:0]   cell_in, cell_char, cell_want;
  logic [MAX_PATTERN-1:0]               cell_hit, cell_active;
  logic [MPOS_W-1:0]                    pos_ext, len_m1_ext, fwd_pos, back_sum, back_pos;
  out_word_t                            res_word;

  always_comb begin
    plen_d = plen_q;
    back_d = back_q;
    pat_d  = pat_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_LENGTH:  plen_d   = cfg_wdata_i[4:0];
        CFG_SEARCH_BACKWARD: back_d   = cfg_wdata_i[0];
        CFG_PATTERN_WORD_0:  pat_d[0] = cfg_wdata_i;
        CFG_PATTERN_WORD_1:  pat_d[1] = cfg_wdata_i;
        CFG_PATTERN_WORD_2:  pat_d[2] = cfg_wdata_i;
        CFG_PATTERN_WORD_3:  pat_d[3] = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign pat_chars = pat_chars_t'(pat_q);
  assign plen_ext  = LW'(plen_q);
  assign len_eff   = (plen_q == 5'd0) ? LW'(1) :
                     (plen_ext > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : plen_ext;

  assign accept    = in_i.valid && buf_ready;
  assign in_i.ready = buf_ready;
  assign cell_ctl.shift = accept && !done_q;
  assign cell_ctl.clear = accept && in_i.scan_end;

  assign cell_in[0] = in_i.char_code;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LW-1:0] want_idx;

    if (k > 0) begin : g_link
      assign cell_in[k] = cell_char[k-1];
    end

    assign want_idx       = back_q ? LW'(k) : LW'(len_eff - LW'(1) - LW'(k));
    assign cell_want[k]   = pat_char(pat_chars, PIDX_W'(want_idx));
    assign cell_active[k] = LW'(k) < len_eff;

    bss_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (cell_ctl),
      .char_i   (cell_in[k]),
      .want_i   (cell_want[k]),
      .active_i (cell_active[k]),
      .char_o   (cell_char[k]),
      .hit_o    (cell_hit[k])
    );
  end

  assign fill_nxt = (fill_q < LW'(MAX_PATTERN)) ? fill_q + LW'(1) : fill_q;
  assign hit_now  = (&cell_hit) && (fill_nxt >= len_eff);

  assign pos_ext    = MPOS_W'(in_i.char_position);
  assign len_m1_ext = MPOS_W'(len_eff - LW'(1));
  assign fwd_pos    = (pos_ext >= len_m1_ext) ? pos_ext - len_m1_ext : '0;
  assign back_sum   = pos_ext + MPOS_W'(len_eff);
  assign back_pos   = (32'(back_sum) > BUF_SZ) ? BUF_CAP : back_sum;

  always_comb begin
    res_push = 1'b0;
    res_word.found = hit_now;
    res_word.match_position = '0;
    if (accept && !done_q) begin
      if (hit_now) begin
        res_push = 1'b1;
        res_word.match_position = back_q ? back_pos : fwd_pos;
      end else if (in_i.scan_end) begin
        res_push = 1'b1;
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    done_d = done_q;
    if (accept) begin
      if (in_i.scan_end) begin
        fill_d = '0;
        done_d = 1'b0;
      end else if (!done_q) begin
        fill_d = fill_nxt;
        done_d = hit_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= 5'd1;
      back_q <= 1'b0;
      pat_q  <= '0;
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      plen_q <= plen_d;
      back_q <= back_d;
      pat_q  <= pat_d;
      fill_q <= fill_d;
      done_q <= done_d;
    end
  end

  bss_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .word_i  (res_word),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

  `BSS_ASSERT(a_fill_bound, fill_q <= LW'(MAX_PATTERN), "window fill above depth")
  `BSS_ASSERT(a_quiet_after_match, done_q |-> !res_push, "result after the scan matched")
  `BSS_ASSERT_NEXT(a_match_latches, res_push && hit_now && !in_i.scan_end, done_q, "match lost")
  `BSS_ASSERT_NEXT(a_scan_end_clears, cell_ctl.clear, fill_q == '0 && !done_q, "scan not cleared")

endmodule
